### rtl/sm2fa_pkg.sv
// ----------------------------------------------------------------------------
// sm2fa_pkg: shared types and constants of the SM2 field arithmetic unit
// Field prime, Montgomery one, exponents, payload structs, datapath commands.
// ----------------------------------------------------------------------------
package sm2fa_pkg;

	localparam int FE_W = 256;

	localparam logic [FE_W-1:0] MOD_P =
		256'hFFFFFFFE_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_00000000_FFFFFFFF_FFFFFFFF;
	localparam logic [FE_W-1:0] MONT_ONE =
		256'h00000001_00000000_00000000_00000000_00000000_FFFFFFFF_00000000_00000001;
	localparam logic [FE_W-1:0] EXP_INV =
		256'hFFFFFFFE_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_00000000_FFFFFFFF_FFFFFFFD;
	localparam logic [FE_W-1:0] EXP_SQRT =
		256'h3FFFFFFF_BFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_C0000000_40000000_00000000;

	// action codes
	localparam logic [2:0] ACT_ADD  = 3'd0;
	localparam logic [2:0] ACT_SUB  = 3'd1;
	localparam logic [2:0] ACT_NEG  = 3'd2;
	localparam logic [2:0] ACT_MUL  = 3'd3;
	localparam logic [2:0] ACT_INV  = 3'd4;
	localparam logic [2:0] ACT_SQRT = 3'd5;

	// datapath operations
	localparam logic [3:0] CMD_NOP  = 4'd0;
	localparam logic [3:0] CMD_LOAD = 4'd1;
	localparam logic [3:0] CMD_ADD  = 4'd2;
	localparam logic [3:0] CMD_SUB  = 4'd3;
	localparam logic [3:0] CMD_NEG  = 4'd4;
	localparam logic [3:0] CMD_FIXC = 4'd5;
	localparam logic [3:0] CMD_FIXB = 4'd6;
	localparam logic [3:0] CMD_MST  = 4'd7;
	localparam logic [3:0] CMD_MACC = 4'd8;
	localparam logic [3:0] CMD_MRED = 4'd9;
	localparam logic [3:0] CMD_XSET = 4'd10;
	localparam logic [3:0] CMD_RES  = 4'd11;

	// multiplier operand pairs
	localparam logic [1:0] SEL_XX = 2'd0;
	localparam logic [1:0] SEL_XA = 2'd1;
	localparam logic [1:0] SEL_AB = 2'd2;

	// result sources
	localparam logic [1:0] SRC_T    = 2'd0;
	localparam logic [1:0] SRC_X    = 2'd1;
	localparam logic [1:0] SRC_CHK  = 2'd2;
	localparam logic [1:0] SRC_ZERO = 2'd3;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] a_word0;
		logic [63:0] a_word1;
		logic [63:0] a_word2;
		logic [63:0] a_word3;
		logic [63:0] b_word0;
		logic [63:0] b_word1;
		logic [63:0] b_word2;
		logic [63:0] b_word3;
	} in_item_t;

	typedef struct packed {
		logic [63:0] res_word0;
		logic [63:0] res_word1;
		logic [63:0] res_word2;
		logic [63:0] res_word3;
		logic        no_root;
	} out_item_t;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] sel;
		logic [1:0] src;
	} dp_cmd_t;

	// subtract p once when the value is p or more
	function automatic logic [FE_W-1:0] fe_reduce(input logic [FE_W-1:0] x);
		fe_reduce = (x >= MOD_P) ? (x - MOD_P) : x;
	endfunction

endpackage

### rtl/sm2fa_datapath.sv
// ----------------------------------------------------------------------------
// sm2fa_datapath: operand, accumulator and result registers
// Executes one command per cycle: modular add/sub steps, bit-serial
// Montgomery multiply steps, exponent accumulator update, result write.
// ----------------------------------------------------------------------------
module sm2fa_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sm2fa_pkg::dp_cmd_t    cmd,
	input  sm2fa_pkg::in_item_t   in_item,
	output sm2fa_pkg::out_item_t  out_item
);
	import sm2fa_pkg::*;

	logic [FE_W-1:0] a_q, b_q, x_q, mb_q, ms_q;
	logic [FE_W+1:0] t_q;
	logic [FE_W-1:0] res_q;
	logic            no_root_q;
	logic [FE_W-1:0] a_in, b_in, t_low;
	logic            over_p, chk_bad;
	logic [FE_W+1:0] t_red;

	assign a_in = {in_item.a_word3, in_item.a_word2, in_item.a_word1, in_item.a_word0};
	assign b_in = {in_item.b_word3, in_item.b_word2, in_item.b_word1, in_item.b_word0};
	assign t_low = t_q[FE_W-1:0];
	assign over_p = t_q[FE_W] || (t_low >= MOD_P);
	assign chk_bad = (t_low != a_q);
	assign t_red = t_q + (t_q[0] ? {2'b00, MOD_P} : '0);

	// execute datapath command
	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_LOAD: begin
				a_q <= fe_reduce(a_in);
				b_q <= fe_reduce(b_in);
				x_q <= MONT_ONE;
			end
			CMD_ADD: t_q <= {2'b00, a_q} + {2'b00, b_q};
			CMD_SUB: t_q <= {2'b00, a_q} - {2'b00, b_q};
			CMD_NEG: t_q <= '0 - {2'b00, a_q};
			CMD_FIXC: t_q <= {2'b00, over_p ? (t_low - MOD_P) : t_low};
			CMD_FIXB: t_q <= {2'b00, t_q[FE_W+1] ? (t_low + MOD_P) : t_low};
			CMD_MST: begin
				t_q <= '0;
				case (cmd.sel)
					SEL_XX: begin
						mb_q <= x_q;
						ms_q <= x_q;
					end
					SEL_XA: begin
						mb_q <= a_q;
						ms_q <= x_q;
					end
					default: begin
						mb_q <= b_q;
						ms_q <= a_q;
					end
				endcase
			end
			CMD_MACC: t_q <= t_q + (ms_q[0] ? {2'b00, mb_q} : '0);
			CMD_MRED: begin
				t_q  <= {1'b0, t_red[FE_W+1:1]};
				ms_q <= {1'b0, ms_q[FE_W-1:1]};
			end
			CMD_XSET: x_q <= t_low;
			CMD_RES: begin
				case (cmd.src)
					SRC_T: begin
						res_q     <= t_low;
						no_root_q <= 1'b0;
					end
					SRC_X: begin
						res_q     <= x_q;
						no_root_q <= 1'b0;
					end
					SRC_CHK: begin
						res_q     <= chk_bad ? '0 : x_q;
						no_root_q <= chk_bad;
					end
					default: begin
						res_q     <= '0;
						no_root_q <= 1'b0;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign out_item.res_word0 = res_q[63:0];
	assign out_item.res_word1 = res_q[127:64];
	assign out_item.res_word2 = res_q[191:128];
	assign out_item.res_word3 = res_q[255:192];
	assign out_item.no_root   = no_root_q;

	// a folding step always leaves a reduced value
	a_fix_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == CMD_FIXC || cmd.op == CMD_FIXB) |=>
		(t_q[FE_W+1:FE_W] == 2'b00) && (t_q[FE_W-1:0] < MOD_P))
		else $error("fold step left value not below p");

	// the reduction step always sees an even sum after adding p
	a_red_even: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == CMD_MRED) |-> (t_red[0] == 1'b0))
		else $error("Montgomery reduction sum is odd");

	// the multiply accumulator stays below 2p between bit steps
	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == CMD_MRED) |=> (t_q[FE_W+1] == 1'b0))
		else $error("Montgomery accumulator overflow");

endmodule

### rtl/sm2fa_ctrl.sv
// ----------------------------------------------------------------------------
// sm2fa_ctrl: sequencer of the SM2 field arithmetic unit
// Walks each action through datapath commands; runs the exponent ladder
// for inverse and square root; owns the input and output handshakes.
// ----------------------------------------------------------------------------
module sm2fa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         in_action,
	output logic               out_valid,
	input  logic               out_ready,
	output sm2fa_pkg::dp_cmd_t cmd
);
	import sm2fa_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_OP   = 4'd1;
	localparam logic [3:0] S_FIX  = 4'd2;
	localparam logic [3:0] S_MST  = 4'd3;
	localparam logic [3:0] S_MACC = 4'd4;
	localparam logic [3:0] S_MRED = 4'd5;
	localparam logic [3:0] S_MFIX = 4'd6;
	localparam logic [3:0] S_POST = 4'd7;
	localparam logic [3:0] S_NEXT = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	// what a finished multiply feeds
	localparam logic [1:0] PH_MUL = 2'd0;
	localparam logic [1:0] PH_SQ  = 2'd1;
	localparam logic [1:0] PH_MA  = 2'd2;
	localparam logic [1:0] PH_CHK = 2'd3;

	logic [3:0] state_q, state_d;
	logic [2:0] act_q, act_d;
	logic [1:0] ph_q, ph_d, msel_q, msel_d, src_q, src_d;
	logic [7:0] cnt_q, cnt_d, idx_q, idx_d;
	logic       out_valid_q, out_valid_d;
	logic       exp_bit, out_free;

	assign exp_bit  = (act_q == ACT_INV) ? EXP_INV[idx_q] : EXP_SQRT[idx_q];
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and datapath command
	always_comb begin
		state_d = state_q;
		act_d   = act_q;
		ph_d    = ph_q;
		msel_d  = msel_q;
		src_d   = src_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd = '{op: CMD_NOP, sel: msel_q, src: src_q};
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = CMD_LOAD;
					act_d  = in_action;
					idx_d  = 8'hFF;
					case (in_action) inside
						ACT_ADD, ACT_SUB, ACT_NEG: state_d = S_OP;
						ACT_MUL: begin
							msel_d  = SEL_AB;
							ph_d    = PH_MUL;
							state_d = S_MST;
						end
						ACT_INV, ACT_SQRT: begin
							msel_d  = SEL_XX;
							ph_d    = PH_SQ;
							state_d = S_MST;
						end
						default: begin
							src_d   = SRC_ZERO;
							state_d = S_FIN;
						end
					endcase
				end
			end
			S_OP: begin
				case (act_q)
					ACT_ADD: cmd.op = CMD_ADD;
					ACT_SUB: cmd.op = CMD_SUB;
					default: cmd.op = CMD_NEG;
				endcase
				state_d = S_FIX;
			end
			S_FIX: begin
				cmd.op  = (act_q == ACT_ADD) ? CMD_FIXC : CMD_FIXB;
				src_d   = SRC_T;
				state_d = S_FIN;
			end
			S_MST: begin
				cmd.op  = CMD_MST;
				cnt_d   = '0;
				state_d = S_MACC;
			end
			S_MACC: begin
				cmd.op  = CMD_MACC;
				state_d = S_MRED;
			end
			S_MRED: begin
				cmd.op  = CMD_MRED;
				cnt_d   = cnt_q + 8'd1;
				state_d = (cnt_q == 8'hFF) ? S_MFIX : S_MACC;
			end
			S_MFIX: begin
				cmd.op  = CMD_FIXC;
				state_d = S_POST;
			end
			S_POST: begin
				case (ph_q)
					PH_MUL: begin
						src_d   = SRC_T;
						state_d = S_FIN;
					end
					PH_SQ: begin
						cmd.op = CMD_XSET;
						if (exp_bit) begin
							msel_d  = SEL_XA;
							ph_d    = PH_MA;
							state_d = S_MST;
						end else begin
							state_d = S_NEXT;
						end
					end
					PH_MA: begin
						cmd.op  = CMD_XSET;
						state_d = S_NEXT;
					end
					default: begin
						src_d   = SRC_CHK;
						state_d = S_FIN;
					end
				endcase
			end
			S_NEXT: begin
				msel_d  = SEL_XX;
				state_d = S_MST;
				if (idx_q != 8'd0) begin
					idx_d = idx_q - 8'd1;
					ph_d  = PH_SQ;
				end else if (act_q == ACT_INV) begin
					src_d   = SRC_X;
					state_d = S_FIN;
				end else begin
					ph_d = PH_CHK;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.op      = CMD_RES;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// advance control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			act_q       <= '0;
			ph_q        <= PH_MUL;
			msel_q      <= SEL_XX;
			src_q       <= SRC_ZERO;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			act_q       <= act_d;
			ph_q        <= ph_d;
			msel_q      <= msel_d;
			src_q       <= src_d;
			cnt_q       <= cnt_d;
			idx_q       <= idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	// an accepted transaction always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != S_IDLE))
		else $error("accepted transaction left sequencer idle");

	// a result write never overruns a waiting result
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == CMD_RES) |-> (!out_valid_q || out_ready))
		else $error("result written over pending transaction");

	// the last bit step of a multiply goes to the final fold
	a_mul_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MRED && cnt_q == 8'hFF) |=> (state_q == S_MFIX))
		else $error("multiply bit count broken");

endmodule

### rtl/sm2_field_alu.sv
// ----------------------------------------------------------------------------
// sm2_field_alu: arithmetic unit over the SM2 prime field
// Add, subtract, negate, Montgomery multiply, inverse and square root.
// ----------------------------------------------------------------------------
// One transaction at a time; the finished result waits in the output register
// while the next transaction is taken. Add, subtract and negate pass through an
// operation step and a fold step before the result write; unused codes go straight
// to the result write. A Montgomery multiply runs radix-2, one accumulate and one
// reduce step per operand bit, then a final fold. Inverse and square root run a
// square-and-multiply ladder over a fixed 256-bit exponent: one squaring per
// exponent bit and one more multiply per set exponent bit (one more multiply
// checks the root).
module sm2_field_alu (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sm2fa_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sm2fa_pkg::out_item_t out_item
);
	import sm2fa_pkg::*;

	dp_cmd_t cmd;

	sm2fa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_action (in_item.action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	sm2fa_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_item  (in_item),
		.out_item (out_item)
	);

endmodule

### bench/sm2fa_checker.sv
// ----------------------------------------------------------------------------
// sm2fa_checker: result predictor and scoreboard of the SM2 field unit
// Watches both channels, computes the expected field result for every
// accepted input transaction and compares each output transaction with it.
// ----------------------------------------------------------------------------
module sm2fa_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  sm2fa_pkg::in_item_t  in_item,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  sm2fa_pkg::out_item_t out_item,
	output int                   errors,
	output int                   outstanding,
	output int                   checked,
	output int                   non_squares
);
	import sm2fa_pkg::*;

	out_item_t field_results_q[$];

	// bring an operand below p
	function automatic logic [255:0] below_p(input logic [255:0] x);
		below_p = (x >= MOD_P) ? x - MOD_P : x;
	endfunction

	function automatic logic [255:0] field_add(input logic [255:0] x, input logic [255:0] y);
		logic [256:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, MOD_P}) begin
			s = s - {1'b0, MOD_P};
		end
		field_add = s[255:0];
	endfunction

	function automatic logic [255:0] field_sub(input logic [255:0] x, input logic [255:0] y);
		field_sub = (x >= y) ? x - y : x - y + MOD_P;
	endfunction

	// x*y*2^-256 mod p, reduced 32 bits at a time (-1/p mod 2^32 is 1)
	function automatic logic [255:0] mont_product(input logic [255:0] x, input logic [255:0] y);
		logic [543:0] t;
		logic [31:0]  m;
		int           i;
		t = {288'd0, x} * {288'd0, y};
		for (i = 0; i < 8; i++) begin
			m = t[31:0];
			t = (t + {512'd0, m} * {288'd0, MOD_P}) >> 32;
		end
		if (t >= {288'd0, MOD_P}) begin
			t = t - {288'd0, MOD_P};
		end
		mont_product = t[255:0];
	endfunction

	// square-and-multiply from the top exponent bit down
	function automatic logic [255:0] mont_power(input logic [255:0] base, input logic [255:0] e);
		logic [255:0] x;
		int           bit_i;
		x = MONT_ONE;
		for (bit_i = 255; bit_i >= 0; bit_i--) begin
			x = mont_product(x, x);
			if (e[bit_i]) begin
				x = mont_product(x, base);
			end
		end
		mont_power = x;
	endfunction

	function automatic out_item_t field_result(input in_item_t it);
		logic [255:0] a, b, r;
		logic         flag;
		out_item_t    o;
		a = below_p({it.a_word3, it.a_word2, it.a_word1, it.a_word0});
		b = below_p({it.b_word3, it.b_word2, it.b_word1, it.b_word0});
		r = '0;
		flag = 1'b0;
		case (it.action)
			ACT_ADD: begin
				r = field_add(a, b);
			end
			ACT_SUB: begin
				r = field_sub(a, b);
			end
			ACT_NEG: begin
				r = field_sub('0, a);
			end
			ACT_MUL: begin
				r = mont_product(a, b);
			end
			ACT_INV: begin
				r = mont_power(a, EXP_INV);
			end
			ACT_SQRT: begin
				r = mont_power(a, EXP_SQRT);
				if (mont_product(r, r) != a) begin
					r = '0;
					flag = 1'b1;
				end
			end
			default: begin
				r = '0;
			end
		endcase
		o.res_word0 = r[63:0];
		o.res_word1 = r[127:64];
		o.res_word2 = r[191:128];
		o.res_word3 = r[255:192];
		o.no_root = flag;
		field_result = o;
	endfunction

	// predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			errors <= 0;
			checked <= 0;
			non_squares <= 0;
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready) begin
				field_results_q.push_back(field_result(in_item));
			end
			if (out_valid && out_ready) begin
				if (field_results_q.size() == 0) begin
					if (errors < 10) begin
						$display("unexpected result transaction: %h", out_item);
					end
					errors <= errors + 1;
				end else begin
					want = field_results_q.pop_front();
					checked <= checked + 1;
					if (want.no_root) begin
						non_squares <= non_squares + 1;
					end
					if (want.res_word0 !== out_item.res_word0 ||
					    want.res_word1 !== out_item.res_word1 ||
					    want.res_word2 !== out_item.res_word2 ||
					    want.res_word3 !== out_item.res_word3 ||
					    want.no_root !== out_item.no_root) begin
						if (errors < 10) begin
							$display("mismatch on result %0d", checked);
							$display("  expected %h %h %h %h no_root %b",
								want.res_word3, want.res_word2, want.res_word1,
								want.res_word0, want.no_root);
							$display("  actual   %h %h %h %h no_root %b",
								out_item.res_word3, out_item.res_word2,
								out_item.res_word1, out_item.res_word0, out_item.no_root);
						end
						errors <= errors + 1;
					end
				end
			end
			outstanding <= field_results_q.size();
		end
	end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the SM2 field arithmetic unit
// Directed extremes and special cases, then random add, subtract, negate,
// multiply and unused codes with random idling on both channels and one long
// output stall. Checking is done by the checker module beside the block.
// ----------------------------------------------------------------------------
module tb;
	import sm2fa_pkg::*;

	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;
	localparam logic [255:0] ALL_ONES = '1;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;
	int        errors;
	int        outstanding;
	int        checked;
	int        non_squares;
	int        sent;
	int        drained;
	bit        stall_done;

	sm2_field_alu u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	sm2fa_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.errors(errors), .outstanding(outstanding), .checked(checked),
		.non_squares(non_squares)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop well beyond the slowest correct run
	initial begin
		#80000000;
		$display("status: fail");
		$finish;
	end

	function automatic logic [255:0] rand_wide();
		rand_wide = {$urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom};
	endfunction

	// mix of extremes, near-p values and full random values
	function automatic logic [255:0] rand_operand();
		case ($urandom_range(9))
			0: rand_operand = '0;
			1: rand_operand = 256'($urandom_range(15));
			2: rand_operand = MOD_P - 256'($urandom_range(1, 1000));
			3: rand_operand = MOD_P + 256'($urandom_range(0, 1000));
			4: rand_operand = ALL_ONES - 256'($urandom_range(3));
			default: rand_operand = rand_wide();
		endcase
	endfunction

	// offer one transaction and hold it until accepted
	task automatic send_op(input logic [2:0] act, input logic [255:0] a, input logic [255:0] b);
		in_item_t it;
		it = '{act, a[63:0], a[127:64], a[191:128], a[255:192],
			b[63:0], b[127:64], b[191:128], b[255:192]};
		if ((sent < 300 || sent >= 450) && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	// receiver: random idling, one quiet window, one long hold-off
	initial begin
		int cyc;
		int hold;
		out_ready = 1'b0;
		cyc = 0;
		drained = 0;
		stall_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!stall_done && drained >= 60) begin
				stall_done = 1'b1;
				out_ready <= 1'b0;
				for (hold = 0; hold < 4000; hold++) @(posedge clk);
			end
			if (cyc >= 30000 && cyc < 80000) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 19);
			end
			@(posedge clk);
			cyc++;
			if (out_valid && out_ready) begin
				drained++;
			end
		end
	end

	initial begin
		int i;
		int r;
		int wait_cyc;
		logic [2:0] act;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of add, subtract, negate, multiply, unused codes
		send_op(ACT_ADD, MOD_P - 1, MOD_P - 1);
		send_op(ACT_ADD, ALL_ONES, ALL_ONES);
		send_op(ACT_ADD, '0, '0);
		send_op(ACT_ADD, MOD_P, 256'd1);
		send_op(ACT_SUB, '0, 256'd1);
		send_op(ACT_SUB, MOD_P - 1, ALL_ONES);
		send_op(ACT_SUB, ALL_ONES, '0);
		send_op(ACT_NEG, '0, ALL_ONES);
		send_op(ACT_NEG, MOD_P, '0);
		send_op(ACT_NEG, 256'd1, '0);
		send_op(ACT_MUL, ALL_ONES, ALL_ONES);
		send_op(ACT_MUL, MOD_P - 1, MOD_P - 1);
		send_op(ACT_MUL, MONT_ONE, rand_wide());
		send_op(ACT_MUL, '0, ALL_ONES);
		send_op(ACT_SPARE6, ALL_ONES, ALL_ONES);
		send_op(ACT_SPARE7, MOD_P - 1, 256'd1);
		// slow ladder cases: zero, nonzero, square, non-square (-1 is one here)
		send_op(ACT_INV, '0, ALL_ONES);
		send_op(ACT_INV, rand_wide(), '0);
		send_op(ACT_SQRT, '0, '0);
		send_op(ACT_SQRT, MONT_ONE, '0);
		send_op(ACT_SQRT, MOD_P - MONT_ONE, '0);

		// random part
		for (i = 0; i < 850; i++) begin
			r = $urandom_range(99);
			if (r < 25) act = ACT_ADD;
			else if (r < 50) act = ACT_SUB;
			else if (r < 65) act = ACT_NEG;
			else if (r < 90) act = ACT_MUL;
			else if (r < 95) act = ACT_SPARE6;
			else act = ACT_SPARE7;
			send_op(act, rand_operand(), rand_operand());
		end
		in_valid <= 1'b0;

		// drain
		wait_cyc = 0;
		while (outstanding != 0 || checked < sent) begin
			@(posedge clk);
			wait_cyc++;
			if (wait_cyc > 600000) begin
				$display("drain timed out with %0d results missing", sent - checked);
				$display("status: fail");
				$finish;
			end
		end
		repeat (50) @(posedge clk);

		$display("covered %0d transactions: directed extremes, inverse and square root", sent);
		$display("cases, %0d non-square roots, random add/sub/neg/mul/unused codes", non_squares);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", errors);
			$display("status: fail");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/sm2fa_pkg.sv
rtl/sm2fa_datapath.sv
rtl/sm2fa_ctrl.sv
rtl/sm2_field_alu.sv
bench/sm2fa_checker.sv
bench/tb.sv
